>>> src/priority_queue_min_extract_assert.svh
// Assertion macros for the priority queue.
`ifndef PRIORITY_QUEUE_MIN_EXTRACT_ASSERT_SVH
`define PRIORITY_QUEUE_MIN_EXTRACT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PQME_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define PQME_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define PQME_ASSERT(label, prop, msg)

`define PQME_ASSERT_RST(label, prop, msg)

`endif

`endif

>>> src/pqme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqme_pkg;

   localparam int PRIO_W = 8;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [PRIO_W-1:0]        prio;
      logic signed [DATA_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type entry;
   } ctrl_type;

endpackage

`default_nettype wire

>>> src/pqme_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pqme_cell (
   input  wire                      clock,
   input  wire                      occupied,
   input  wire pqme_pkg::ctrl_type  ctrl,
   input  wire                      left_before,
   input  wire pqme_pkg::entry_type left_entry,
   input  wire pqme_pkg::entry_type right_entry,
   output logic                     ahead,
   output pqme_pkg::entry_type      entry
);
   import pqme_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // new entry lands ahead of this one; equal priorities stay behind
   assign ahead = !occupied || (ctrl.entry.prio < entry_ff.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (ahead) begin
            entry_in = left_before ? left_entry : ctrl.entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

>>> src/priority_queue_min_extract.sv
// Channel | Direction | Ports
// req     | in        | req_valid, req_ready, req_cmd, req_priority_req, req_payload
// rsp     | out       | rsp_valid, rsp_ready, rsp_status, rsp_out_priority,
//         |           | rsp_out_payload, rsp_occupancy
//
// One item per cycle unless a held result stalls; each result is registered.
// Entries sit sorted in a row of cells; each cell compares one priority per cycle.
// Reset clears the fill count and the result valid flag; cell contents need no clear.
// A stalled result holds the input only when the result register is still occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_queue_min_extract_assert.svh"

module priority_queue_min_extract #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_cmd,
   input  wire  [pqme_pkg::PRIO_W-1:0]        req_priority_req,
   input  wire  signed [pqme_pkg::DATA_W-1:0] req_payload,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [pqme_pkg::STAT_W-1:0]        rsp_status,
   output logic [pqme_pkg::PRIO_W-1:0]        rsp_out_priority,
   output logic signed [pqme_pkg::DATA_W-1:0] rsp_out_payload,
   output logic [pqme_pkg::OCC_W-1:0]         rsp_occupancy
);
   import pqme_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic [PRIO_W-1:0]        prio_ff, prio_in;
   logic signed [DATA_W-1:0] payload_ff, payload_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;

   logic     req_fire, full, empty, ins_ok, rem_ok;
   ctrl_type ctrl;
   logic [OCC_W+CNT_W-1:0] count_ext;

   entry_type              cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_before;
   logic [QUEUE_DEPTH-1:0] cell_occupied;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);
   assign ins_ok    = req_fire && (req_cmd == CMD_INSERT) && !full;
   assign rem_ok    = req_fire && (req_cmd == CMD_REMOVE) && !empty;

   assign ctrl.insert        = ins_ok;
   assign ctrl.remove        = rem_ok;
   assign ctrl.entry.prio    = req_priority_req;
   assign ctrl.entry.payload = req_payload;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_before;

      assign cell_occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_before = 1'b0;
         assign left_entry  = '0;
      end else begin : g_mid
         assign left_before = cell_before[i-1];
         assign left_entry  = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      pqme_cell u_cell (
         .clock       (clock),
         .occupied    (cell_occupied[i]),
         .ctrl        (ctrl),
         .left_before (left_before),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ahead       (cell_before[i]),
         .entry       (cell_entry[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + 1'b1;
      end else if (rem_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign count_ext = {{OCC_W{1'b0}}, count_in};

   always_comb begin
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);
      status_in    = status_ff;
      prio_in      = prio_ff;
      payload_in   = payload_ff;
      occ_in       = occ_ff;
      if (req_fire) begin
         status_in  = ST_OK;
         prio_in    = '0;
         payload_in = '0;
         occ_in     = count_ext[OCC_W-1:0];
         if (req_cmd == CMD_INSERT) begin
            if (full) begin
               status_in = ST_FULL;
            end
         end else if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            prio_in    = cell_entry[0].prio;
            payload_in = cell_entry[0].payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
      occ_ff     <= occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_priority = prio_ff;
   assign rsp_out_payload  = payload_ff;
   assign rsp_occupancy    = occ_ff;

   `PQME_ASSERT_RST(a_reset_clears, reset |=> (!rsp_valid_ff && count_ff == '0), "reset did not clear")
   `PQME_ASSERT(a_count_bound, count_ff <= FULL_COUNT, "fill count above depth")
   `PQME_ASSERT(a_insert_grows, ins_ok |=> (count_ff == $past(count_ff) + 1'b1), "insert lost")
   `PQME_ASSERT(a_remove_ok, rem_ok |=> (rsp_valid_ff && status_ff == ST_OK), "remove status wrong")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pqme_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_GAP     = 20;
   localparam int PHASE_ITEMS = 500;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [PRIO_W-1:0]        prio;
      logic signed [DATA_W-1:0] payload;
      logic [OCC_W-1:0]         occupancy;
   } queue_outcome_type;

   typedef struct packed {
      logic                     cmd;
      logic [PRIO_W-1:0]        prio;
      logic signed [DATA_W-1:0] data;
      logic                     typed;
      queue_outcome_type        want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_cmd = CMD_INSERT;
   logic [PRIO_W-1:0]        req_priority_req = '0;
   logic signed [DATA_W-1:0] req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic [PRIO_W-1:0]        rsp_out_priority;
   logic signed [DATA_W-1:0] rsp_out_payload;
   logic [OCC_W-1:0]         rsp_occupancy;

   logic                     row_typed = 1'b0;
   queue_outcome_type        row_want = '0;

   entry_type         held_entries[$];
   queue_outcome_type outcomes_due[$];
   stim_row_type      directed_rows[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;

   priority_queue_min_extract #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_occupancy    (rsp_occupancy)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still due", cycle_count,
                  outcomes_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic queue_outcome_type apply_queue_op(input logic cmd,
                                                        input logic [PRIO_W-1:0] prio,
                                                        input logic signed [DATA_W-1:0] data);
      queue_outcome_type res;
      entry_type         ent;
      int                best;
      res = '0;
      res.status = ST_OK;
      if (cmd == CMD_INSERT) begin
         if (held_entries.size() >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            ent.prio = prio;
            ent.payload = data;
            held_entries.push_back(ent);
         end
      end else if (held_entries.size() == 0) begin
         res.status = ST_EMPTY;
      end else begin
         best = 0;
         for (int i = 1; i < held_entries.size(); i++) begin
            if (held_entries[i].prio < held_entries[best].prio) best = i;
         end
         res.prio = held_entries[best].prio;
         res.payload = held_entries[best].payload;
         held_entries.delete(best);
      end
      res.occupancy = OCC_W'(held_entries.size());
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (mismatch_count < 100)
         $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                  cycle_count);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : scoreboard
      queue_outcome_type predicted;
      queue_outcome_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = apply_queue_op(req_cmd, req_priority_req, req_payload);
            outcomes_due.push_back(row_typed ? row_want : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch("item with nothing due", '0, '0);
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", DATA_W'(rsp_status), DATA_W'(want.status));
               if (rsp_out_priority !== want.prio)
                  report_mismatch("out_priority", DATA_W'(rsp_out_priority),
                                  DATA_W'(want.prio));
               if (rsp_out_payload !== want.payload)
                  report_mismatch("out_payload", rsp_out_payload, want.payload);
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch("occupancy", DATA_W'(rsp_occupancy),
                                  DATA_W'(want.occupancy));
            end
         end
      end
   end

   function automatic void add_row(input logic cmd, input logic [PRIO_W-1:0] prio,
                                   input logic signed [DATA_W-1:0] data, input logic typed,
                                   input logic [STAT_W-1:0] status,
                                   input logic [PRIO_W-1:0] oprio,
                                   input logic signed [DATA_W-1:0] opay,
                                   input logic [OCC_W-1:0] occ);
      stim_row_type row;
      row.cmd = cmd;
      row.prio = prio;
      row.data = data;
      row.typed = typed;
      row.want.status = status;
      row.want.prio = oprio;
      row.want.payload = opay;
      row.want.occupancy = occ;
      directed_rows.push_back(row);
   endfunction

   function automatic int sender_gap();
      int gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      return gap;
   endfunction

   // call at a rising edge; returns at the edge where the item is taken
   task automatic send_item(input logic cmd, input logic [PRIO_W-1:0] prio,
                            input logic signed [DATA_W-1:0] data, input logic typed,
                            input queue_outcome_type want);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_priority_req <= prio;
      req_payload <= data;
      row_typed <= typed;
      row_want <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outcomes_due.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int                       insert_pct;
      logic                     cmd;
      logic [PRIO_W-1:0]        prio;
      logic signed [DATA_W-1:0] data;

      add_row(CMD_REMOVE, 8'd0, 32'shDEADBEEF, 1'b1, ST_EMPTY, 8'd0, 32'sd0, 5'd0);
      add_row(CMD_INSERT, 8'd255, 32'sh7FFFFFFF, 1'b1, ST_OK, 8'd0, 32'sd0, 5'd1);
      add_row(CMD_INSERT, 8'd0, 32'sh80000000, 1'b1, ST_OK, 8'd0, 32'sd0, 5'd2);
      add_row(CMD_REMOVE, 8'd255, 32'shFFFFFFFF, 1'b1, ST_OK, 8'd0, 32'sh80000000, 5'd1);
      add_row(CMD_REMOVE, 8'd0, 32'sd0, 1'b1, ST_OK, 8'd255, 32'sh7FFFFFFF, 5'd0);
      add_row(CMD_REMOVE, 8'd17, 32'sd5, 1'b1, ST_EMPTY, 8'd0, 32'sd0, 5'd0);
      // fill with repeated priorities so ties resolve by arrival
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         prio = (k % 3 == 0) ? 8'd255 : ((k % 3 == 1) ? 8'd0 : 8'd128);
         add_row(CMD_INSERT, prio, DATA_W'(k) * 32'sh11111111, 1'b0, ST_OK, 8'd0, 32'sd0,
                 5'd0);
      end
      add_row(CMD_INSERT, 8'd1, 32'sh00001234, 1'b1, ST_FULL, 8'd0, 32'sd0, 5'd16);
      add_row(CMD_REMOVE, 8'd0, 32'sd0, 1'b0, ST_OK, 8'd0, 32'sd0, 5'd0);
      add_row(CMD_REMOVE, 8'd0, 32'sd0, 1'b0, ST_OK, 8'd0, 32'sd0, 5'd0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_item(directed_rows[r].cmd, directed_rows[r].prio, directed_rows[r].data,
                   directed_rows[r].typed, directed_rows[r].want);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         insert_pct = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // shift the insert bias in bursts so the queue swings between full and empty
            if (n % 40 == 0) begin
               case ($urandom_range(3))
                  0: insert_pct = 15;
                  1: insert_pct = 50;
                  2: insert_pct = 85;
                  default: insert_pct = 97;
               endcase
            end
            cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            case ($urandom_range(3))
               0: prio = PRIO_W'($urandom_range(3));
               1: prio = $urandom_range(1) ? 8'd255 : 8'd0;
               default: prio = PRIO_W'($urandom_range(255));
            endcase
            case ($urandom_range(7))
               0: data = 32'sh80000000;
               1: data = 32'sh7FFFFFFF;
               default: data = $urandom;
            endcase
            send_item(cmd, prio, data, 1'b0, '0);
         end
         drain_results();
      end

      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
